@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tilt block assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("tilt block forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

@@ hw/rtl/atpr_pkg.sv @@
// types, constants and cordic helpers for the accelerometer tilt block
package atpr_pkg;

  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ACC_FRAC        = 20;
  localparam int TABLE_LEN       = 24;
  localparam int CORDIC_N        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

  localparam int SQRT_N = 24;   // one result bit per cell, 48-bit radicand
  localparam int RAD_W  = 48;
  localparam int ROOT_W = 24;
  localparam int REM_W  = 25;
  localparam int XY_W   = 27;
  localparam int ANG_W  = 30;
  localparam int IDX_W  = 5;
  localparam int RND_SH = ACC_FRAC - ANGLE_FRAC_BITS;

  localparam logic signed [ANG_W-1:0] DEG90    = ANG_W'(90 << ACC_FRAC);
  localparam logic signed [ANG_W-1:0] ROLL_LIM = ANG_W'(180 << ANGLE_FRAC_BITS);
  localparam logic signed [ANG_W-1:0] PITCH_LIM = ANG_W'(90 << ANGLE_FRAC_BITS);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [14:0] pitch_deg;
    logic signed [15:0] roll_deg;
  } out_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] ang;
  } rot_t;

  // word moving through the square root cells, roll rotates alongside
  typedef struct packed {
    logic [RAD_W-1:0]   rad;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    rot_t               roll;
    logic signed [15:0] ax;
  } sqrt_word_t;

  typedef struct packed {
    rot_t                    pitch;
    logic signed [ANG_W-1:0] roll_ang;
  } pitch_word_t;

  // atan(2^-i) in degrees, 20 fraction bits
  function automatic logic signed [ANG_W-1:0] atan_deg(input logic [IDX_W-1:0] i);
    logic signed [ANG_W-1:0] t;
    unique case (i)
      5'd0:    t = ANG_W'(47185920);
      5'd1:    t = ANG_W'(27855475);
      5'd2:    t = ANG_W'(14718068);
      5'd3:    t = ANG_W'(7471121);
      5'd4:    t = ANG_W'(3750058);
      5'd5:    t = ANG_W'(1876857);
      5'd6:    t = ANG_W'(938658);
      5'd7:    t = ANG_W'(469357);
      5'd8:    t = ANG_W'(234682);
      5'd9:    t = ANG_W'(117342);
      5'd10:   t = ANG_W'(58671);
      5'd11:   t = ANG_W'(29335);
      5'd12:   t = ANG_W'(14668);
      5'd13:   t = ANG_W'(7334);
      5'd14:   t = ANG_W'(3667);
      5'd15:   t = ANG_W'(1833);
      5'd16:   t = ANG_W'(917);
      5'd17:   t = ANG_W'(458);
      5'd18:   t = ANG_W'(229);
      5'd19:   t = ANG_W'(115);
      5'd20:   t = ANG_W'(57);
      5'd21:   t = ANG_W'(29);
      5'd22:   t = ANG_W'(14);
      5'd23:   t = ANG_W'(7);
      default: t = '0;
    endcase
    return t;
  endfunction

  // one vectoring step: drive y toward zero, y of zero leaves the vector alone
  function automatic rot_t cordic_rot(input rot_t a, input logic [IDX_W-1:0] i);
    rot_t                    r;
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ANG_W-1:0] t;
    dx = $signed(a.y) >>> i;
    dy = $signed(a.x) >>> i;
    t  = atan_deg(i);
    r  = a;
    if (!a.y[XY_W-1] && (a.y != '0)) begin
      r.x   = a.x + dx;
      r.y   = a.y - dy;
      r.ang = a.ang + t;
    end else if (a.y[XY_W-1]) begin
      r.x   = a.x - dx;
      r.y   = a.y + dy;
      r.ang = a.ang - t;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/atpr_sqrt_cell.sv @@
// square root cell: one root bit per cycle while en is high, one roll cordic step in cells below CORDIC_N
module atpr_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [atpr_pkg::IDX_W-1:0]    idx,
  input  logic                          in_vld,
  input  atpr_pkg::sqrt_word_t          in_w,
  output logic                          out_vld,
  output atpr_pkg::sqrt_word_t          out_w
);

  localparam int CUR_W = atpr_pkg::REM_W + 2;

  atpr_pkg::sqrt_word_t word_next;
  logic [CUR_W-1:0]     cur;
  logic [CUR_W-1:0]     trial;
  logic [CUR_W-1:0]     diff;

  always_comb begin
    cur   = {in_w.rem, in_w.rad[atpr_pkg::RAD_W-1 -: 2]};
    trial = {1'b0, in_w.root, 2'b01};
    diff  = cur - trial;
    word_next     = in_w;
    word_next.rad = {in_w.rad[atpr_pkg::RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      word_next.rem  = diff[atpr_pkg::REM_W-1:0];
      word_next.root = {in_w.root[atpr_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      word_next.rem  = cur[atpr_pkg::REM_W-1:0];
      word_next.root = {in_w.root[atpr_pkg::ROOT_W-2:0], 1'b0};
    end
    // roll only uses the first cordic_n cells
    if (int'(idx) < atpr_pkg::CORDIC_N) begin
      word_next.roll = atpr_pkg::cordic_rot(in_w.roll, idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w <= word_next;
    end
  end

endmodule

@@ hw/rtl/atpr_pitch_cell.sv @@
// pitch cordic cell: one vectoring step, roll angle rides along
module atpr_pitch_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [atpr_pkg::IDX_W-1:0]    idx,
  input  logic                          in_vld,
  input  atpr_pkg::pitch_word_t         in_w,
  output logic                          out_vld,
  output atpr_pkg::pitch_word_t         out_w
);

  atpr_pkg::pitch_word_t word_next;

  always_comb begin
    word_next       = in_w;
    word_next.pitch = atpr_pkg::cordic_rot(in_w.pitch, idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_w <= word_next;
    end
  end

endmodule

@@ hw/rtl/accel_tilt_pitch_roll.sv @@
// top level of the accelerometer tilt block: roll and pitch from one sample
// Usage:
//   sample channel (sample_valid/sample_ready/sample) takes one raw x/y/z word,
//   angle channel (angle_valid/angle_ready/angle) gives pitch_deg and roll_deg
//   in 1/128 degree, one angle word per sample word, in order.
// Pipeline: from the accepting edge to angle_valid a word passes one squaring
//   stage, 24 square root cells (the roll cordic runs in the first cells),
//   the CORDIC_N pitch cordic cells and the output register.
// Throughput: one word per cycle while skid_v is low, when every cell moves.
// Stall: when angle_ready is low the output register holds its word and a
//   one-word skid register catches the word leaving the chain; once the skid
//   register is full sample_ready drops and the whole chain freezes in place.
// Reset: rst clears all valid flags, the chain is empty, sample_ready is high
//   in the first cycle after reset.
module accel_tilt_pitch_roll (
  input  logic            clk,
  input  logic            rst,
  input  logic            sample_valid,
  output logic            sample_ready,
  input  atpr_pkg::in_t   sample,
  output logic            angle_valid,
  input  logic            angle_ready,
  output atpr_pkg::out_t  angle
);

`include "assert_macros.svh"

  localparam int SQ = atpr_pkg::SQRT_N;
  localparam int CN = atpr_pkg::CORDIC_N;
  localparam int XY = atpr_pkg::XY_W;

  logic en;
  logic skid_v;
  logic out_v;
  atpr_pkg::out_t skid_d;
  atpr_pkg::out_t out_d;

  // squaring stage
  logic signed [31:0]       sq_y;
  logic signed [31:0]       sq_z;
  logic [31:0]              sumsq;
  logic signed [XY-1:0]     zs;
  logic signed [XY-1:0]     ys;
  atpr_pkg::sqrt_word_t     s0_next;
  logic                     s0_v;
  atpr_pkg::sqrt_word_t     s0_w;

  logic                     lane_v [SQ+1];
  atpr_pkg::sqrt_word_t     lane_w [SQ+1];
  logic                     pc_v   [CN+1];
  atpr_pkg::pitch_word_t    pc_w   [CN+1];
  atpr_pkg::pitch_word_t    pc_in;

  logic signed [XY-1:0]                ax_s;
  logic signed [atpr_pkg::ANG_W-1:0]   roll_r;
  logic signed [atpr_pkg::ANG_W-1:0]   pitch_r;
  atpr_pkg::out_t                      res_next;

  assign en           = !skid_v;
  assign sample_ready = !skid_v;

  always_comb begin
    sq_y  = sample.accel_y * sample.accel_y;
    sq_z  = sample.accel_z * sample.accel_z;
    sumsq = $unsigned(sq_y) + $unsigned(sq_z);
    zs    = {{(XY-24){sample.accel_z[15]}}, sample.accel_z, 8'b0};
    ys    = {{(XY-24){sample.accel_y[15]}}, sample.accel_y, 8'b0};
    s0_next      = '0;
    s0_next.rad  = {sumsq, 16'b0};
    s0_next.ax   = sample.accel_x;
    // left half plane: turn by 90 degrees first
    if (zs[XY-1]) begin
      if (!ys[XY-1]) begin
        s0_next.roll.x   = ys;
        s0_next.roll.y   = -zs;
        s0_next.roll.ang = atpr_pkg::DEG90;
      end else begin
        s0_next.roll.x   = -ys;
        s0_next.roll.y   = zs;
        s0_next.roll.ang = -atpr_pkg::DEG90;
      end
    end else begin
      s0_next.roll.x   = zs;
      s0_next.roll.y   = ys;
      s0_next.roll.ang = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (en) begin
      s0_v <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_w <= s0_next;
    end
  end

  assign lane_v[0] = s0_v;
  assign lane_w[0] = s0_w;

  for (genvar g = 0; g < SQ; g++) begin : g_sqrt
    atpr_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .idx     (atpr_pkg::IDX_W'(g)),
      .in_vld  (lane_v[g]),
      .in_w    (lane_w[g]),
      .out_vld (lane_v[g+1]),
      .out_w   (lane_w[g+1])
    );
  end

  // pitch vector: x is the floored square root magnitude, never in the left half plane
  always_comb begin
    ax_s = {{(XY-24){lane_w[SQ].ax[15]}}, lane_w[SQ].ax, 8'b0};
    pc_in.pitch.x   = {{(XY-atpr_pkg::ROOT_W){1'b0}}, lane_w[SQ].root};
    pc_in.pitch.y   = -ax_s;
    pc_in.pitch.ang = '0;
    pc_in.roll_ang  = lane_w[SQ].roll.ang;
  end
  assign pc_w[0] = pc_in;
  assign pc_v[0] = lane_v[SQ];

  for (genvar g = 0; g < CN; g++) begin : g_pitch
    atpr_pitch_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .idx     (atpr_pkg::IDX_W'(g)),
      .in_vld  (pc_v[g]),
      .in_w    (pc_w[g]),
      .out_vld (pc_v[g+1]),
      .out_w   (pc_w[g+1])
    );
  end

  // round to nearest, ties up, then clamp
  function automatic logic signed [atpr_pkg::ANG_W-1:0] round_clamp(
    input logic signed [atpr_pkg::ANG_W-1:0] a,
    input logic signed [atpr_pkg::ANG_W-1:0] lim
  );
    logic signed [atpr_pkg::ANG_W-1:0] r;
    r = (a + atpr_pkg::ANG_W'(1 << (atpr_pkg::RND_SH - 1))) >>> atpr_pkg::RND_SH;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    return r;
  endfunction

  always_comb begin
    roll_r  = round_clamp(pc_w[CN].roll_ang, atpr_pkg::ROLL_LIM);
    pitch_r = round_clamp(pc_w[CN].pitch.ang, atpr_pkg::PITCH_LIM);
    res_next.pitch_deg = pitch_r[14:0];
    res_next.roll_deg  = roll_r[15:0];
  end

  // output register plus one-word skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || angle_ready) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= pc_v[CN];
      end
    end else if (pc_v[CN] && en) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || angle_ready) begin
      out_d <= skid_v ? skid_d : res_next;
    end else if (pc_v[CN] && en) begin
      skid_d <= res_next;
    end
  end

  assign angle_valid = out_v;
  assign angle       = out_d;

  `ASSERT_NEVER(a_skid_needs_out, clk, rst, skid_v && !out_v)
  `ASSERT_CLK(a_skid_fill_on_stall, clk, rst, $rose(skid_v) |-> $past(out_v && !angle_ready))
  `ASSERT_CLK(a_roll_range, clk, rst, angle_valid |-> (angle.roll_deg <= 16'sd23040 && angle.roll_deg >= -16'sd23040))
  `ASSERT_CLK(a_pitch_range, clk, rst, angle_valid |-> (angle.pitch_deg <= 15'sd11520 && angle.pitch_deg >= -15'sd11520))

endmodule

@@ verif/testbench.sv @@
// testbench for accel_tilt_pitch_roll: random and corner samples checked against a tilt predictor
`timescale 1ns / 1ps

module testbench;

  localparam int FRAC_SH   = atpr_pkg::ACC_FRAC - atpr_pkg::ANGLE_FRAC_BITS;
  localparam int STEPS     = (atpr_pkg::CORDIC_STAGES < 24) ? atpr_pkg::CORDIC_STAGES : 24;
  localparam int N_RANDOM  = 1500;
  localparam int DRAIN     = 80;
  localparam longint QUARTER_TURN = longint'(90) <<< atpr_pkg::ACC_FRAC;

  // atan(2^-i) in degrees, 20 fraction bits
  localparam longint ATAN_STEP_DEG [0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           sample_valid = 1'b0;
  logic           sample_ready;
  atpr_pkg::in_t  sample = '0;
  logic           angle_valid;
  logic           angle_ready = 1'b0;
  atpr_pkg::out_t angle;

  atpr_pkg::in_t  pending_samples[$];
  atpr_pkg::out_t expected_angles[$];
  int             samples_total;
  int             samples_sent = 0;
  int             results_seen = 0;
  int             mismatches = 0;

  accel_tilt_pitch_roll dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .angle_valid  (angle_valid),
    .angle_ready  (angle_ready),
    .angle        (angle)
  );

  always #5 clk = ~clk;

  // vectoring rotation toward the x axis, angle in degrees with 20 fraction bits
  function automatic longint vector_angle(longint xv, longint yv);
    longint ang;
    longint t;
    longint dx;
    longint dy;
    int     i;
    ang = 0;
    if (xv < 0) begin
      t = xv;
      if (yv >= 0) begin
        xv  = yv;
        yv  = -t;
        ang = QUARTER_TURN;
      end else begin
        xv  = -yv;
        yv  = t;
        ang = -QUARTER_TURN;
      end
    end
    for (i = 0; i < STEPS; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv  = xv + dx;
        yv  = yv - dy;
        ang = ang + ATAN_STEP_DEG[i];
      end else if (yv < 0) begin
        xv  = xv - dx;
        yv  = yv + dy;
        ang = ang - ATAN_STEP_DEG[i];
      end
    end
    return ang;
  endfunction

  // round half up to the output grid, then clamp to +-lim_deg
  function automatic longint round_clamp(longint ang, longint lim_deg);
    longint r;
    longint lim;
    r   = (ang + (longint'(1) <<< (FRAC_SH - 1))) >>> FRAC_SH;
    lim = lim_deg <<< atpr_pkg::ANGLE_FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic atpr_pkg::out_t tilt_angles(atpr_pkg::in_t s);
    atpr_pkg::out_t   w;
    longint           ax;
    longint           ay;
    longint           az;
    longint unsigned  rad;
    longint unsigned  root;
    longint unsigned  trial;
    longint           pitch;
    longint           roll;
    int               b;
    ax  = longint'(s.accel_x);
    ay  = longint'(s.accel_y);
    az  = longint'(s.accel_z);
    rad = longint'(ay * ay + az * az) << 16;
    // floor square root, one bit at a time from the top
    root = 0;
    for (b = 23; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= rad) root = trial;
    end
    roll  = round_clamp(vector_angle(az * 256, ay * 256), 180);
    pitch = round_clamp(vector_angle(longint'(root), -ax * 256), 90);
    w.pitch_deg = 15'(pitch);
    w.roll_deg  = 16'(roll);
    return w;
  endfunction

  task automatic add_sample(int x, int y, int z);
    atpr_pkg::in_t s;
    s.accel_x = 16'(x);
    s.accel_y = 16'(y);
    s.accel_z = 16'(z);
    pending_samples.push_back(s);
  endtask

  function automatic int pick_extreme();
    int v;
    case ($urandom_range(5))
      0: v = -32768;
      1: v = -32767;
      2: v = -1;
      3: v = 0;
      4: v = 1;
      default: v = 32767;
    endcase
    return v;
  endfunction

  // sample driver
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && sample_ready) begin
        expected_angles.push_back(tilt_angles(sample));
        samples_sent <= samples_sent + 1;
      end
      if (!sample_valid || sample_ready) begin
        if (pending_samples.size() != 0 &&
            ((samples_sent >= 700 && samples_sent < 1000) || $urandom_range(99) >= 28)) begin
          sample       <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  // angle monitor
  always @(posedge clk) begin
    atpr_pkg::out_t want;
    if (rst) begin
      angle_ready <= 1'b0;
    end else begin
      if (angle_valid && angle_ready) begin
        results_seen <= results_seen + 1;
        if (expected_angles.size() == 0) begin
          $error("angle word with none expected: pitch_deg %0d roll_deg %0d",
                 angle.pitch_deg, angle.roll_deg);
          mismatches++;
        end else begin
          want = expected_angles.pop_front();
          if (angle.pitch_deg !== want.pitch_deg) begin
            $error("pitch_deg expected %0d got %0d", want.pitch_deg, angle.pitch_deg);
            mismatches++;
          end
          if (angle.roll_deg !== want.roll_deg) begin
            $error("roll_deg expected %0d got %0d", want.roll_deg, angle.roll_deg);
            mismatches++;
          end
        end
      end
      angle_ready <= (results_seen >= 700 && results_seen < 1000) || $urandom_range(99) >= 28;
    end
  end

  initial begin
    int k;
    int g;
    // zero vector, axis directions, quadrant edges and full-scale corners
    add_sample(0, 0, 0);
    add_sample(5, 0, 0);
    add_sample(0, 0, -1);
    add_sample(0, 0, -32768);
    add_sample(0, 0, 1);
    add_sample(0, 1, 0);
    add_sample(0, -1, 0);
    add_sample(0, -32768, 0);
    add_sample(0, 32767, 0);
    add_sample(32767, 0, 0);
    add_sample(-32768, 0, 0);
    add_sample(-32768, 0, 1);
    add_sample(32767, 0, -1);
    add_sample(1, 1, 1);
    add_sample(-1, -1, -1);
    add_sample(0, -1, -1);
    add_sample(0, 1, -1);
    add_sample(32767, 32767, 32767);
    add_sample(-32768, -32768, -32768);
    add_sample(-32768, 32767, -32768);
    add_sample(0, 16384, 16384);
    add_sample(16384, 0, 16384);
    add_sample(-16384, -16384, 0);

    for (k = 0; k < N_RANDOM; k++) begin
      case ($urandom_range(4))
        0: add_sample($urandom_range(65535), $urandom_range(65535), $urandom_range(65535));
        1: add_sample(int'($urandom_range(64)) - 32, int'($urandom_range(64)) - 32,
                      int'($urandom_range(64)) - 32);
        2: begin
          // near one g along a random axis, small noise elsewhere
          g = ($urandom_range(1) ? 16384 : -16384) + int'($urandom_range(2000)) - 1000;
          case ($urandom_range(2))
            0: add_sample(g, int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000);
            1: add_sample(int'($urandom_range(4000)) - 2000, g, int'($urandom_range(4000)) - 2000);
            default: add_sample(int'($urandom_range(4000)) - 2000,
                                int'($urandom_range(4000)) - 2000, g);
          endcase
        end
        3: add_sample($urandom_range(1) ? 0 : $urandom_range(65535),
                      $urandom_range(1) ? 0 : $urandom_range(65535),
                      $urandom_range(1) ? 0 : $urandom_range(65535));
        default: add_sample(pick_extreme(), pick_extreme(), pick_extreme());
      endcase
    end
    samples_total = pending_samples.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    do @(posedge clk);
    while (samples_sent < samples_total || expected_angles.size() != 0);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
